// ===== rtl/ljsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljsd_pkg
// Shared types, codes and constants of the liveview jpeg stream deframer.
// ----------------------------------------------------------------------------
package ljsd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_COMMON = 3'd2,
    PH_SKIP   = 3'd3,
    PH_PHDR   = 3'd4,
    PH_DATA   = 3'd5,
    PH_PAD    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_IMAGE = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] TYPE_IMAGE      = 8'h01;
  localparam logic [7:0] TYPE_IMAGE_EXT  = 8'h11;
  localparam logic [7:0] TYPE_INFO       = 8'h12;

  localparam logic [7:0] COMMON_REST_LEN = 8'd6;
  localparam logic [7:0] INFO_SKIP_LEN   = 8'd160;
  localparam logic [7:0] PAYLOAD_HDR_LEN = 8'd128;
  localparam logic [7:0] START_CODE_LEN  = 8'd4;
  localparam logic [7:0] PADDING_POS     = 8'd7;

  // one result of the parser for one byte
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    kind_t      kind;
    logic       frame_last;
  } result_t;

  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [7:0] code;
    case (idx)
      2'd0:    code = 8'h24;
      2'd1:    code = 8'h35;
      2'd2:    code = 8'h68;
      default: code = 8'h79;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/ljsd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljsd stream interfaces
// Valid/ready channels for raw stream bytes and for deframer results.
// ----------------------------------------------------------------------------
interface ljsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ljsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       frame_last;

  modport source (output valid, output out_byte, output kind, output frame_last,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input frame_last,
                  output ready);
endinterface

// ===== rtl/ljsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljsd_parser
// Per-byte header parser: state registers and the single-pass step logic
// that turns one stream byte into zero or one result.
// ----------------------------------------------------------------------------
module ljsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  output ljsd_pkg::result_t  result
);

  ljsd_pkg::phase_t phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic        packet_type_info, packet_type_info_next;
  logic        start_code_ok, start_code_ok_next;
  logic [23:0] jpeg_remaining, jpeg_remaining_next;
  logic [7:0]  padding_left, padding_left_next;

  logic [7:0]  pos_inc;
  logic [23:0] jpeg_dec;
  logic [7:0]  pad_dec;

  assign pos_inc  = byte_position + 8'd1;
  assign jpeg_dec = jpeg_remaining - 24'd1;
  assign pad_dec  = padding_left - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ljsd_pkg::PH_HUNT;
      byte_position    <= '0;
      packet_type_info <= 1'b0;
      start_code_ok    <= 1'b1;
      jpeg_remaining   <= '0;
      padding_left     <= '0;
    end else if (step) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      packet_type_info <= packet_type_info_next;
      start_code_ok    <= start_code_ok_next;
      jpeg_remaining   <= jpeg_remaining_next;
      padding_left     <= padding_left_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    packet_type_info_next = packet_type_info;
    start_code_ok_next    = start_code_ok;
    jpeg_remaining_next   = jpeg_remaining;
    padding_left_next     = padding_left;
    result                = '0;
    result.kind           = ljsd_pkg::KIND_IMAGE;

    case (phase)
      ljsd_pkg::PH_TYPE: begin
        if (data_byte inside {ljsd_pkg::TYPE_INFO, ljsd_pkg::TYPE_IMAGE_EXT,
                              ljsd_pkg::TYPE_IMAGE}) begin
          packet_type_info_next = (data_byte == ljsd_pkg::TYPE_INFO);
          byte_position_next    = '0;
          phase_next            = ljsd_pkg::PH_COMMON;
        end else if (data_byte != ljsd_pkg::SYNC_BYTE) begin
          phase_next = ljsd_pkg::PH_HUNT;
        end
      end

      ljsd_pkg::PH_COMMON: begin
        byte_position_next = pos_inc;
        if (pos_inc >= ljsd_pkg::COMMON_REST_LEN) begin
          byte_position_next = '0;
          if (packet_type_info) begin
            phase_next = ljsd_pkg::PH_SKIP;
          end else begin
            start_code_ok_next  = 1'b1;
            jpeg_remaining_next = '0;
            padding_left_next   = '0;
            phase_next          = ljsd_pkg::PH_PHDR;
          end
        end
      end

      ljsd_pkg::PH_SKIP: begin
        byte_position_next = pos_inc;
        if (pos_inc >= ljsd_pkg::INFO_SKIP_LEN) begin
          byte_position_next = '0;
          phase_next         = ljsd_pkg::PH_HUNT;
        end
      end

      ljsd_pkg::PH_PHDR: begin
        if (byte_position < ljsd_pkg::START_CODE_LEN) begin
          if (data_byte != ljsd_pkg::start_code_byte(byte_position[1:0])) begin
            start_code_ok_next = 1'b0;
          end
        end else if (byte_position < ljsd_pkg::PADDING_POS) begin
          // image size, big endian
          jpeg_remaining_next = {jpeg_remaining[15:0], data_byte};
        end else if (byte_position == ljsd_pkg::PADDING_POS) begin
          padding_left_next = data_byte;
        end
        byte_position_next = pos_inc;
        if (pos_inc >= ljsd_pkg::PAYLOAD_HDR_LEN) begin
          byte_position_next = '0;
          // the start code and size bytes are all behind us by now
          if (!start_code_ok) begin
            phase_next   = ljsd_pkg::PH_HUNT;
            result.valid = 1'b1;
            result.kind  = ljsd_pkg::KIND_ERROR;
          end else if (jpeg_remaining == '0) begin
            phase_next   = (padding_left != '0) ? ljsd_pkg::PH_PAD : ljsd_pkg::PH_HUNT;
            result.valid = 1'b1;
            result.kind  = ljsd_pkg::KIND_EMPTY;
          end else begin
            phase_next = ljsd_pkg::PH_DATA;
          end
        end
      end

      ljsd_pkg::PH_DATA: begin
        jpeg_remaining_next = jpeg_dec;
        result.valid        = 1'b1;
        result.out_byte     = data_byte;
        result.kind         = ljsd_pkg::KIND_IMAGE;
        result.frame_last   = (jpeg_dec == '0);
        if (jpeg_dec == '0) begin
          phase_next = (padding_left != '0) ? ljsd_pkg::PH_PAD : ljsd_pkg::PH_HUNT;
        end
      end

      ljsd_pkg::PH_PAD: begin
        if (padding_left != '0) begin
          padding_left_next = pad_dec;
        end
        if (padding_left_next == '0) begin
          phase_next = ljsd_pkg::PH_HUNT;
        end
      end

      default: begin
        // hunting, and the unused phase code
        phase_next = (data_byte == ljsd_pkg::SYNC_BYTE) ? ljsd_pkg::PH_TYPE
                                                        : ljsd_pkg::PH_HUNT;
      end
    endcase
  end

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == ljsd_pkg::PH_DATA |-> jpeg_remaining != '0)
    else $error("data phase with no image bytes left");

  a_pad_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == ljsd_pkg::PH_PAD |-> padding_left != '0)
    else $error("padding phase with no padding left");

  a_skip_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == ljsd_pkg::PH_SKIP |-> byte_position < ljsd_pkg::INFO_SKIP_LEN)
    else $error("info skip count out of range");

  a_hdr_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == ljsd_pkg::PH_PHDR |-> byte_position < ljsd_pkg::PAYLOAD_HDR_LEN)
    else $error("payload header count out of range");

endmodule

// ===== rtl/liveview_jpeg_stream_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liveview_jpeg_stream_deframer_core
// Pulls jpeg image bytes out of a liveview byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and gives at most one result per
// byte: an image byte (last one of a frame flagged), a start code error after
// a bad payload header, or an empty-frame event for an image size of zero.
// Headers, info packets, stray bytes and padding give no result. Each byte
// goes through an input register, one pass of the parser step logic and a
// result register; the parser state update in that single pass sets the
// rate of one byte per cycle, kept up as long as the result side takes
// results.
module liveview_jpeg_stream_deframer_core (
  input  logic          clk,
  input  logic          rst,
  ljsd_byte_if.sink     stream,
  ljsd_result_if.source result
);

  logic       s_valid;
  logic [7:0] s_byte;
  logic       advance;
  logic       step;

  logic       o_valid;
  logic [7:0] o_byte;
  logic [1:0] o_kind;
  logic       o_last;

  ljsd_pkg::result_t step_result;

  // the result slot is free, or is being emptied this cycle
  assign advance      = !o_valid || result.ready;
  assign step         = s_valid && advance;
  assign stream.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (stream.ready) begin
      s_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s_byte <= stream.data_byte;
    end
  end

  ljsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s_byte),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= step && step_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_byte <= step_result.out_byte;
      o_kind <= step_result.kind;
      o_last <= step_result.frame_last;
    end
  end

  assign result.valid      = o_valid;
  assign result.out_byte   = o_byte;
  assign result.kind       = o_kind;
  assign result.frame_last = o_last;

  a_last_is_image: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_last |-> o_kind == ljsd_pkg::KIND_IMAGE)
    else $error("frame_last on an event result");

  a_event_zero_byte: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind != ljsd_pkg::KIND_IMAGE |-> o_byte == 8'd0)
    else $error("event result with a nonzero byte");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !advance |=> s_valid && $stable(s_byte))
    else $error("input register lost a byte under stall");

endmodule
